// File: sv/hfm_pkg.sv
// ----------------------------------------------------------------------------
// hfm_pkg: shared types and constants of the heartbeat failure monitor
// Opcodes, notice kinds, failure marks, register indexes and the structs
// that link the sequencer to the row of host cells.
// ----------------------------------------------------------------------------
package hfm_pkg;

  // sizes fixed by the beat fields
  localparam int unsigned HFM_HOSTS      = 16;
  localparam int unsigned HOST_W         = 4;
  localparam int unsigned MASK_W         = 16;
  localparam int unsigned INTERVAL_W     = 16;
  localparam int unsigned MISS_W         = 8;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  // register reset values
  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL   = INTERVAL_W'(10);
  localparam logic [MISS_W-1:0]     RESET_MAX_MISSES = MISS_W'(3);

  typedef enum logic [2:0] {
    OP_ALIVE     = 3'd0,
    OP_HEARTBEAT = 3'd1,
    OP_CHECK     = 3'd2,
    OP_PING_ACK  = 3'd3,
    OP_FAIL_ACK  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_PING   = 2'd0,
    KIND_FAILED = 2'd1,
    KIND_REPEAT = 2'd2
  } notice_e;

  typedef enum logic [1:0] {
    MARK_NONE    = 2'd0,
    MARK_UNACKED = 2'd1,
    MARK_ACKED   = 2'd2
  } mark_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK       = 2'd0,
    CFG_INTERVAL   = 2'd1,
    CFG_MAX_MISSES = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_FLUSH = 2'd2
  } state_e;

  // configuration registers
  typedef struct packed {
    logic [MASK_W-1:0]     mask;
    logic [INTERVAL_W-1:0] interval;
    logic [MISS_W-1:0]     max_misses;
  } cfg_t;

  // tick under way
  typedef struct packed {
    logic              check;
    logic [TIME_W-1:0] now;
  } sweep_t;

  // single-host event, valid for one cycle
  typedef struct packed {
    logic              valid;
    opcode_e           op;
    logic [HOST_W-1:0] host;
    logic [TIME_W-1:0] now;
  } dir_t;

  // notice raised by the cell holding the token
  typedef struct packed {
    logic              hit;
    notice_e           kind;
    logic [HOST_W-1:0] id;
  } res_t;

endpackage

// File: sv/hfm_cell.sv
// ----------------------------------------------------------------------------
// hfm_cell: state of one monitored host
// Holds last-heard time, miss count, in-flight mark and failure mark, takes
// single-host events directly and handles a tick while it holds the token.
// ----------------------------------------------------------------------------
module hfm_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tok_i,
  input  logic           adv_i,
  input  logic           en_i,
  input  hfm_pkg::cfg_t   cfg_i,
  input  hfm_pkg::sweep_t sweep_i,
  input  hfm_pkg::dir_t   dir_i,
  output logic           tok_o,
  output hfm_pkg::res_t   res_o
);
  import hfm_pkg::*;

  logic              tok_q;
  logic [TIME_W-1:0] heard_q, heard_d;
  logic [MISS_W-1:0] miss_q, miss_d;
  logic              infl_q, infl_d;
  mark_e             mark_q, mark_d;

  logic              match;
  logic [TIME_W-1:0] age;
  logic              ping;
  logic [MISS_W-1:0] miss_inc;
  logic              fail;

  assign match = dir_i.valid && (32'(dir_i.host) == 32'(IDX));

  // tick evaluation for this host
  assign age      = sweep_i.now - heard_q;
  assign ping     = en_i && !(age < TIME_W'(cfg_i.interval));
  assign miss_inc = (miss_q == '1) ? miss_q : miss_q + MISS_W'(1);
  assign fail     = infl_q && (miss_inc >= cfg_i.max_misses) && (mark_q != MARK_ACKED);

  always_comb begin
    res_o    = '0;
    res_o.id = HOST_W'(IDX);
    if (tok_q) begin
      if (sweep_i.check) begin
        res_o.hit  = fail;
        res_o.kind = (mark_q == MARK_UNACKED) ? KIND_REPEAT : KIND_FAILED;
      end else begin
        res_o.hit  = ping;
        res_o.kind = KIND_PING;
      end
    end
  end

  // state update
  always_comb begin
    heard_d = heard_q;
    miss_d  = miss_q;
    infl_d  = infl_q;
    mark_d  = mark_q;
    if (tok_q && adv_i) begin
      if (sweep_i.check) begin
        if (infl_q) begin
          miss_d = miss_inc;
          if (fail) begin
            mark_d = MARK_UNACKED;
          end
        end
        infl_d = 1'b0;
      end else begin
        infl_d = ping;
      end
    end else if (match) begin
      case (dir_i.op)
        OP_ALIVE: begin
          if (en_i) begin
            heard_d = dir_i.now;
          end
        end
        OP_PING_ACK: begin
          miss_d = '0;
          infl_d = 1'b0;
        end
        OP_FAIL_ACK: mark_d = MARK_ACKED;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      heard_q <= '0;
      miss_q  <= '0;
      infl_q  <= 1'b0;
      mark_q  <= MARK_NONE;
    end else begin
      if (adv_i) begin
        tok_q <= tok_i;
      end
      heard_q <= heard_d;
      miss_q  <= miss_d;
      infl_q  <= infl_d;
      mark_q  <= mark_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: sv/hfm_ctrl.sv
// ----------------------------------------------------------------------------
// hfm_ctrl: sequencer of the heartbeat failure monitor
// Holds configuration, launches the token for ticks, and queues notices
// through a pending stage and the output register to mark the final beat.
// ----------------------------------------------------------------------------
module hfm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    in_opcode_i,
  input  logic [hfm_pkg::HOST_W-1:0]    in_host_index_i,
  input  logic [hfm_pkg::TIME_W-1:0]    in_now_time_i,
  input  logic                          cfg_we_i,
  input  logic [hfm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hfm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hfm_pkg::HOST_W-1:0]    out_host_id_o,
  output logic [1:0]                    out_notice_kind_o,
  output logic                          out_last_of_run_o,
  input  hfm_pkg::res_t                 res_i,
  input  logic                          last_tok_i,
  output logic                          start_o,
  output logic                          adv_o,
  output hfm_pkg::cfg_t                 cfg_o,
  output hfm_pkg::sweep_t               sweep_o,
  output hfm_pkg::dir_t                 dir_o
);
  import hfm_pkg::*;

  state_e state_q, state_d;
  cfg_t   cfg_q;
  sweep_t sweep_q, sweep_d;

  logic              pend_vld_q, pend_vld_d;
  res_t              pend_q, pend_d;
  logic              out_vld_q, out_vld_d;
  logic [HOST_W-1:0] out_id_q, out_id_d;
  notice_e           out_kind_q, out_kind_d;
  logic              out_last_q, out_last_d;

  logic    accept;
  logic    out_free;
  opcode_e op;

  assign op       = opcode_e'(in_opcode_i);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask       <= '0;
      cfg_q.interval   <= RESET_INTERVAL;
      cfg_q.max_misses <= RESET_MAX_MISSES;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MASK:       cfg_q.mask       <= cfg_wdata_i[MASK_W-1:0];
        CFG_INTERVAL:   cfg_q.interval   <= cfg_wdata_i[INTERVAL_W-1:0];
        CFG_MAX_MISSES: cfg_q.max_misses <= cfg_wdata_i[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  // next state, token launch and notice queue
  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_id_d   = out_id_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    start_o    = 1'b0;
    dir_o      = '0;
    adv_o      = !(res_i.hit && pend_vld_q && !out_free);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_HEARTBEAT || op == OP_CHECK) begin
            start_o       = 1'b1;
            sweep_d.check = (op == OP_CHECK);
            sweep_d.now   = in_now_time_i;
            state_d       = ST_SWEEP;
          end else begin
            dir_o.valid = 1'b1;
            dir_o.op    = op;
            dir_o.host  = in_host_index_i;
            dir_o.now   = in_now_time_i;
          end
        end
      end
      ST_SWEEP: begin
        if (res_i.hit && adv_o) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_id_d   = pend_q.id;
            out_kind_d = pend_q.kind;
            out_last_d = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_d     = res_i;
        end
        if (last_tok_i && adv_o) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_id_d   = pend_q.id;
          out_kind_d = pend_q.kind;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sweep_q    <= sweep_d;
    pend_q     <= pend_d;
    out_id_q   <= out_id_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_vld_q;
  assign out_host_id_o     = out_id_q;
  assign out_notice_kind_o = out_kind_q;
  assign out_last_of_run_o = out_last_q;
  assign cfg_o             = cfg_q;
  assign sweep_o           = sweep_q;

endmodule

// File: sv/heartbeat_failure_monitor.sv
// ----------------------------------------------------------------------------
// heartbeat_failure_monitor: liveness tracking for a set of hosts
// A row of host cells with a token walking through it on ticks, plus a
// sequencer that holds configuration and orders the notices.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid_i/in_stall_o | opcode, host index, time
//   out     | output    | out_valid_o/out_stall_i | host id, notice kind, last
//   cfg     | input     | cfg_we_i             | register index, data
//
// single-host events do not stall the input; the block stays ready for the next beat
// after a tick the input stays stalled while the token crosses the cell row,
// then through the flush state that hands over the final notice
// an output stall while a notice waits holds the token and prolongs the input stall
// reset clears all host state and loads the register defaults at once
// ----------------------------------------------------------------------------
module heartbeat_failure_monitor #(
  parameter int unsigned HOSTS = hfm_pkg::HFM_HOSTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    in_opcode_i,
  input  logic [hfm_pkg::HOST_W-1:0]    in_host_index_i,
  input  logic [hfm_pkg::TIME_W-1:0]    in_now_time_i,
  input  logic                          cfg_we_i,
  input  logic [hfm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hfm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hfm_pkg::HOST_W-1:0]    out_host_id_o,
  output logic [1:0]                    out_notice_kind_o,
  output logic                          out_last_of_run_o
);
  import hfm_pkg::*;

  logic        start;
  logic        adv;
  cfg_t        cfg;
  sweep_t      sweep;
  dir_t        dir;
  res_t        res_any;
  logic [HOSTS:0] tok;
  res_t        res [HOSTS];

  assign tok[0] = start;

  // row of host cells, token handed one cell per cycle while adv is high
  for (genvar i = 0; i < HOSTS; i++) begin : g_cell
    logic en;
    if (i < MASK_W) begin : g_en
      assign en = cfg.mask[i];
    end else begin : g_off
      assign en = 1'b0;
    end

    hfm_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[i]),
      .adv_i   (adv),
      .en_i    (en),
      .cfg_i   (cfg),
      .sweep_i (sweep),
      .dir_i   (dir),
      .tok_o   (tok[i+1]),
      .res_o   (res[i])
    );
  end

  // only the token holder raises a notice
  always_comb begin
    res_any = '0;
    for (int i = 0; i < HOSTS; i++) begin
      if (res[i].hit) begin
        res_any = res_any | res[i];
      end
    end
  end

  hfm_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_opcode_i       (in_opcode_i),
    .in_host_index_i   (in_host_index_i),
    .in_now_time_i     (in_now_time_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_host_id_o     (out_host_id_o),
    .out_notice_kind_o (out_notice_kind_o),
    .out_last_of_run_o (out_last_of_run_o),
    .res_i             (res_any),
    .last_tok_i        (tok[HOSTS]),
    .start_o           (start),
    .adv_o             (adv),
    .cfg_o             (cfg),
    .sweep_o           (sweep),
    .dir_o             (dir)
  );

endmodule

// File: sv/hfm_checker.sv
// ----------------------------------------------------------------------------
// hfm_checker: port-level checks of the heartbeat failure monitor
// Watches the ports only and is attached to the top level by a bind.
// ----------------------------------------------------------------------------
module hfm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [2:0]                    in_opcode_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [hfm_pkg::HOST_W-1:0]    out_host_id_o,
  input logic [1:0]                    out_notice_kind_o,
  input logic                          out_last_of_run_o
);
  import hfm_pkg::*;

  logic in_beat;
  logic tick;

  assign in_beat = in_valid_i && !in_stall_o;
  assign tick    = (in_opcode_i == OP_HEARTBEAT) || (in_opcode_i == OP_CHECK);

  // a stalled notice holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_host_id_o)
      && $stable(out_notice_kind_o) && $stable(out_last_of_run_o))
    else $error("stalled notice changed");

  // a tick occupies the block, a single-host event does not
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && tick |=> in_stall_o)
    else $error("tick did not start a sweep");

  a_direct_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !tick |=> !in_stall_o)
    else $error("single-host event left the block busy");

  // a run is not over while its non-final notice is shown
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_of_run_o |-> in_stall_o)
    else $error("block idle with a run unfinished");

endmodule

bind heartbeat_failure_monitor hfm_checker u_hfm_checker (.*);
